// ===== sv/brbs_pkg.sv =====
// ----------------------------------------------------------------------------
// brbs_pkg
// Shared types and constants for the buddy region block splitter.
// ----------------------------------------------------------------------------
package brbs_pkg;

    localparam int PAGE_W     = 40;
    localparam int PAGES_W    = 20;
    localparam int ADDR_W     = 52;
    localparam int INDEX_W    = 40;
    localparam int ORDER_W    = 4;
    localparam int LOG_W      = 5;
    localparam int PAGE_SHIFT = 12;
    localparam int MAX_OUT    = 62;
    localparam int COUNT_W    = 6;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    typedef struct packed {
        logic               skip;
        logic [PAGE_W-1:0]  page;
        logic [PAGES_W-1:0] pages;
        logic               final_region;
    } region_desc_t;

    typedef enum logic [0:0] {
        BACK_IDLE = 1'b0,
        BACK_RUN  = 1'b1
    } back_state_t;

endpackage

// ===== sv/buddy_region_block_splitter.sv =====
// ----------------------------------------------------------------------------
// buddy_region_block_splitter
// Cuts memory-map regions into aligned buddy blocks and links free lists.
// ----------------------------------------------------------------------------
// A region is transferred when start is high and busy is low; up to two
// regions wait in a queue while the back end splits the current one. The
// back end produces one block per clock, up to 62 per region, once a region
// is loaded, and a skipped region gives a single result; the single order
// search and free-list head update per cycle sets that pace. Each result
// shows on the outputs for exactly one cycle with result_strobe high, and
// the receiver cannot stall it.
// ----------------------------------------------------------------------------
module buddy_region_block_splitter
#(
    parameter int ORDERS       = 16,
    parameter int ADDRESS_BITS = 52
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          region_is_free,
    input  logic [brbs_pkg::PAGE_W-1:0]   region_start_page,
    input  logic [brbs_pkg::PAGES_W-1:0]  region_pages,
    input  logic                          is_final_region,
    output logic                          result_strobe,
    output logic                          block_valid,
    output logic [brbs_pkg::ORDER_W-1:0]  block_order,
    output logic [brbs_pkg::ADDR_W-1:0]   block_address,
    output logic [brbs_pkg::INDEX_W-1:0]  bitmap_index,
    output logic [brbs_pkg::ADDR_W-1:0]   previous_head,
    output logic                          last_of_region,
    output logic                          end_of_map
);

    brbs_pkg::region_desc_t  push_desc;
    brbs_pkg::region_desc_t  pop_desc;
    logic                    push;
    logic                    pop;
    logic                    queue_empty;
    logic                    queue_full;

    brbs_front u_front
    (
        .start             (start),
        .queue_full        (queue_full),
        .region_is_free    (region_is_free),
        .region_start_page (region_start_page),
        .region_pages      (region_pages),
        .is_final_region   (is_final_region),
        .busy              (busy),
        .push              (push),
        .desc              (push_desc)
    );

    brbs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    brbs_back
    #(
        .ORDERS       (ORDERS),
        .ADDRESS_BITS (ADDRESS_BITS)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .queue_empty    (queue_empty),
        .desc           (pop_desc),
        .pop            (pop),
        .result_strobe  (result_strobe),
        .block_valid    (block_valid),
        .block_order    (block_order),
        .block_address  (block_address),
        .bitmap_index   (bitmap_index),
        .previous_head  (previous_head),
        .last_of_region (last_of_region),
        .end_of_map     (end_of_map)
    );

    a_end_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && end_of_map |-> last_of_region)
        else $error("end_of_map without last_of_region");

    a_skip_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !block_valid |->
            last_of_region && (block_order == '0) && (block_address == '0))
        else $error("skipped region result malformed");

    a_page_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && block_valid |->
            (block_address[brbs_pkg::PAGE_SHIFT-1:0] == '0))
        else $error("block address not page aligned");

    a_link_chain: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && block_valid ##1 result_strobe && block_valid &&
            (block_order == $past(block_order)) |->
            (previous_head == $past(block_address)))
        else $error("free-list link broken");

endmodule

// ===== sv/brbs_front.sv =====
// ----------------------------------------------------------------------------
// brbs_front
// Accepts regions and classifies them into skip or split descriptors.
// ----------------------------------------------------------------------------
module brbs_front
(
    input  logic                          start,
    input  logic                          queue_full,
    input  logic                          region_is_free,
    input  logic [brbs_pkg::PAGE_W-1:0]   region_start_page,
    input  logic [brbs_pkg::PAGES_W-1:0]  region_pages,
    input  logic                          is_final_region,
    output logic                          busy,
    output logic                          push,
    output brbs_pkg::region_desc_t        desc
);

    assign busy = queue_full;
    assign push = start && !queue_full;

    always_comb
    begin
        desc.skip         = !region_is_free || (region_pages == '0);
        desc.page         = region_start_page;
        desc.pages        = region_pages;
        desc.final_region = is_final_region;
    end

endmodule

// ===== sv/brbs_queue.sv =====
// ----------------------------------------------------------------------------
// brbs_queue
// Small descriptor queue between the front and back ends.
// ----------------------------------------------------------------------------
module brbs_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  brbs_pkg::region_desc_t  push_desc,
    input  logic                    pop,
    output brbs_pkg::region_desc_t  pop_desc,
    output logic                    empty,
    output logic                    full
);

    brbs_pkg::region_desc_t            entry_reg [brbs_pkg::QDEPTH];
    logic [brbs_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [brbs_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [brbs_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [brbs_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [brbs_pkg::QCNT_W-1:0]       count_reg;
    logic [brbs_pkg::QCNT_W-1:0]       count_next;
    logic                              do_push;
    logic                              do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == brbs_pkg::QCNT_W'(brbs_pkg::QDEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_desc = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== sv/brbs_back.sv =====
// ----------------------------------------------------------------------------
// brbs_back
// Splits one region into aligned power-of-two blocks, one block per cycle,
// and keeps the free-list head of every order.
// ----------------------------------------------------------------------------
module brbs_back
#(
    parameter int ORDERS       = 16,
    parameter int ADDRESS_BITS = 52
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          queue_empty,
    input  brbs_pkg::region_desc_t        desc,
    output logic                          pop,
    output logic                          result_strobe,
    output logic                          block_valid,
    output logic [brbs_pkg::ORDER_W-1:0]  block_order,
    output logic [brbs_pkg::ADDR_W-1:0]   block_address,
    output logic [brbs_pkg::INDEX_W-1:0]  bitmap_index,
    output logic [brbs_pkg::ADDR_W-1:0]   previous_head,
    output logic                          last_of_region,
    output logic                          end_of_map
);

    localparam int ORD_W = (ORDERS > 1) ? $clog2(ORDERS) : 1;
    localparam int PW    = brbs_pkg::PAGE_W + 1;
    localparam logic [brbs_pkg::ADDR_W-1:0] ADDR_MASK =
        (ADDRESS_BITS >= brbs_pkg::ADDR_W) ? {brbs_pkg::ADDR_W{1'b1}} :
        ((brbs_pkg::ADDR_W'(1) << ADDRESS_BITS) - brbs_pkg::ADDR_W'(1));

    brbs_pkg::back_state_t               state_reg;
    brbs_pkg::back_state_t               state_next;
    logic [PW-1:0]                       page_reg;
    logic [PW-1:0]                       page_next;
    logic [brbs_pkg::PAGES_W-1:0]        rem_reg;
    logic [brbs_pkg::PAGES_W-1:0]        rem_next;
    logic                                skip_reg;
    logic                                final_reg;
    logic [brbs_pkg::COUNT_W-1:0]        count_reg;
    logic [brbs_pkg::COUNT_W-1:0]        count_next;
    logic [brbs_pkg::ADDR_W-1:0]         head_reg [ORDERS];

    logic                                strobe_reg;
    logic                                valid_reg;
    logic [brbs_pkg::ORDER_W-1:0]        order_out_reg;
    logic [brbs_pkg::ADDR_W-1:0]         addr_reg;
    logic [brbs_pkg::INDEX_W-1:0]        index_reg;
    logic [brbs_pkg::ADDR_W-1:0]         prev_reg;
    logic                                last_reg;
    logic                                end_reg;

    logic [brbs_pkg::LOG_W-1:0]          align_cap;
    logic [brbs_pkg::LOG_W-1:0]          fit_log;
    logic [ORD_W-1:0]                    order;
    logic [PW-1:0]                       blk_pages;
    logic [brbs_pkg::ADDR_W-1:0]         blk_addr;
    logic                                blk_last;
    logic                                load;
    logic                                emit_block;
    logic                                emit_skip;
    logic                                finish;

    // alignment cap: lowest set bit of the page, limited to ORDERS-1
    always_comb
    begin
        align_cap = brbs_pkg::LOG_W'(ORDERS - 1);
        for (int i = ORDERS - 2; i >= 0; i--)
        begin
            if (page_reg[i])
            begin
                align_cap = brbs_pkg::LOG_W'(i);
            end
        end
    end

    // largest block that fits the remaining pages
    always_comb
    begin
        fit_log = '0;
        for (int i = 0; i < brbs_pkg::PAGES_W; i++)
        begin
            if (rem_reg[i])
            begin
                fit_log = brbs_pkg::LOG_W'(i);
            end
        end
    end

    always_comb
    begin
        order     = ORD_W'((fit_log < align_cap) ? fit_log : align_cap);
        blk_pages = PW'(1) << order;
        page_next = page_reg + blk_pages;
        rem_next  = rem_reg - blk_pages[brbs_pkg::PAGES_W-1:0];
        blk_addr  = {page_reg[brbs_pkg::PAGE_W-1:0], {brbs_pkg::PAGE_SHIFT{1'b0}}}
                    & ADDR_MASK;
        blk_last  = (rem_next == '0) ||
                    (count_reg == brbs_pkg::COUNT_W'(brbs_pkg::MAX_OUT - 1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brbs_pkg::BACK_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = brbs_pkg::BACK_RUN;
                end
            end
            brbs_pkg::BACK_RUN:
            begin
                if (skip_reg || blk_last)
                begin
                    state_next = brbs_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = brbs_pkg::BACK_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        load       = 1'b0;
        emit_block = 1'b0;
        emit_skip  = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            brbs_pkg::BACK_IDLE:
            begin
                load = !queue_empty;
            end
            brbs_pkg::BACK_RUN:
            begin
                emit_skip  = skip_reg;
                emit_block = !skip_reg;
                finish     = skip_reg || blk_last;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    assign pop        = load;
    assign count_next = load ? '0 : count_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= brbs_pkg::BACK_IDLE;
            strobe_reg <= 1'b0;
            count_reg  <= '0;
            for (int i = 0; i < ORDERS; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= emit_block || emit_skip;
            if (load || emit_block)
            begin
                count_reg <= count_next;
            end
            if (emit_block)
            begin
                head_reg[order] <= blk_addr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            page_reg  <= {1'b0, desc.page};
            rem_reg   <= desc.pages;
            skip_reg  <= desc.skip;
            final_reg <= desc.final_region;
        end
        else if (emit_block)
        begin
            page_reg <= page_next;
            rem_reg  <= rem_next;
        end

        if (emit_skip)
        begin
            valid_reg     <= 1'b0;
            order_out_reg <= '0;
            addr_reg      <= '0;
            index_reg     <= '0;
            prev_reg      <= '0;
            last_reg      <= 1'b1;
            end_reg       <= final_reg;
        end
        else if (emit_block)
        begin
            valid_reg     <= 1'b1;
            order_out_reg <= brbs_pkg::ORDER_W'(order);
            addr_reg      <= blk_addr;
            index_reg     <= brbs_pkg::INDEX_W'(page_reg >> order);
            prev_reg      <= head_reg[order];
            last_reg      <= finish;
            end_reg       <= finish && final_reg;
        end
    end

    assign result_strobe  = strobe_reg;
    assign block_valid    = valid_reg;
    assign block_order    = order_out_reg;
    assign block_address  = addr_reg;
    assign bitmap_index   = index_reg;
    assign previous_head  = prev_reg;
    assign last_of_region = last_reg;
    assign end_of_map     = end_reg;

endmodule

// ===== tb/buddy_region_block_splitter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_region_block_splitter_tb
// Self-checking bench for the buddy region block splitter.
// ----------------------------------------------------------------------------
// Regions are sent through the start/busy handshake in random bursts. Each
// accepted region is split into buddy blocks by a local model that keeps its
// own free-list heads, and every strobed result is checked against the
// oldest expected block. Directed regions cover skipped and empty regions,
// page zero, the top of the page space and free-list chaining; random
// regions follow.
// ----------------------------------------------------------------------------
module buddy_region_block_splitter_tb;

    localparam int ORDERS       = 16;
    localparam int ADDRESS_BITS = 52;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 81;

    typedef struct packed {
        logic                         valid;
        logic [brbs_pkg::ORDER_W-1:0] order;
        logic [brbs_pkg::ADDR_W-1:0]  address;
        logic [brbs_pkg::INDEX_W-1:0] index;
        logic [brbs_pkg::ADDR_W-1:0]  prev_head;
        logic                         last;
        logic                         eom;
    } block_rec_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          region_is_free = 1'b0;
    logic [brbs_pkg::PAGE_W-1:0]   region_start_page = '0;
    logic [brbs_pkg::PAGES_W-1:0]  region_pages = '0;
    logic                          is_final_region = 1'b0;
    logic                          result_strobe;
    logic                          block_valid;
    logic [brbs_pkg::ORDER_W-1:0]  block_order;
    logic [brbs_pkg::ADDR_W-1:0]   block_address;
    logic [brbs_pkg::INDEX_W-1:0]  bitmap_index;
    logic [brbs_pkg::ADDR_W-1:0]   previous_head;
    logic                          last_of_region;
    logic                          end_of_map;

    logic [brbs_pkg::ADDR_W-1:0]   list_head [ORDERS];
    block_rec_t                    pending_blocks [$];
    block_rec_t                    got_block;
    block_rec_t                    want_block;
    int                            mismatch_count = 0;
    int                            idle_cycles = 0;
    int                            burst_left = 0;

    buddy_region_block_splitter #(
        .ORDERS       (ORDERS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .region_is_free    (region_is_free),
        .region_start_page (region_start_page),
        .region_pages      (region_pages),
        .is_final_region   (is_final_region),
        .result_strobe     (result_strobe),
        .block_valid       (block_valid),
        .block_order       (block_order),
        .block_address     (block_address),
        .bitmap_index      (bitmap_index),
        .previous_head     (previous_head),
        .last_of_region    (last_of_region),
        .end_of_map        (end_of_map)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Cut one region into blocks and queue the blocks it should produce.
    task automatic split_region(input logic is_free,
                                input logic [brbs_pkg::PAGE_W-1:0] first_page,
                                input logic [brbs_pkg::PAGES_W-1:0] page_count,
                                input logic fin);
        logic [63:0] cur;
        logic [63:0] stop;
        logic [63:0] size;
        logic [63:0] addr_mask;
        block_rec_t  blk;
        int          ord;
        int          n;
        cur = {24'd0, first_page};
        stop = cur + {44'd0, page_count};
        addr_mask = (ADDRESS_BITS >= 64) ? '1 : ((64'd1 << ADDRESS_BITS) - 64'd1);
        n = 0;
        if (!is_free || page_count == '0)
        begin
            blk = '0;
            blk.last = 1'b1;
            blk.eom = fin;
            pending_blocks.push_back(blk);
        end
        else
        begin
            while (cur < stop && n < brbs_pkg::MAX_OUT)
            begin
                if (cur == 64'd0)
                    ord = ORDERS - 1;
                else
                begin
                    ord = 0;
                    while (ord < 63 && !cur[ord])
                        ord++;
                end
                if (ord > ORDERS - 1)
                    ord = ORDERS - 1;
                while (ord > 0 && cur + (64'd1 << ord) > stop)
                    ord--;
                size = 64'd1 << ord;
                blk.valid = 1'b1;
                blk.order = ord[brbs_pkg::ORDER_W-1:0];
                blk.address = brbs_pkg::ADDR_W'((cur << brbs_pkg::PAGE_SHIFT) & addr_mask);
                blk.index = brbs_pkg::INDEX_W'(cur >> ord);
                blk.prev_head = list_head[ord];
                list_head[ord] = blk.address;
                cur = cur + size;
                blk.last = (cur >= stop) || (n == brbs_pkg::MAX_OUT - 1);
                blk.eom = blk.last & fin;
                pending_blocks.push_back(blk);
                n++;
            end
        end
    endtask

    // One region transfer; start is left high so the next region can follow.
    task automatic send_region(input logic is_free,
                               input logic [brbs_pkg::PAGE_W-1:0] first_page,
                               input logic [brbs_pkg::PAGES_W-1:0] page_count,
                               input logic fin);
        region_is_free <= is_free;
        region_start_page <= first_page;
        region_pages <= page_count;
        is_final_region <= fin;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        split_region(is_free, first_page, page_count, fin);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
    endtask

    task automatic test_skipped_regions();
        send_region(1'b0, 40'h12_3456_789A, 20'h00400, 1'b0);
        send_region(1'b1, 40'h00_0000_1000, 20'h00000, 1'b1);
        send_region(1'b0, 40'h00_0000_0000, 20'h00000, 1'b0);
        pace_sender();
        send_region(1'b0, '1, '1, 1'b1);
    endtask

    task automatic test_page_extremes();
        send_region(1'b1, 40'h00_0000_0000, 20'h00001, 1'b0);
        send_region(1'b1, 40'h00_0000_0000, '1, 1'b0);
        pace_sender();
        send_region(1'b1, '1, '1, 1'b1);
        send_region(1'b1, 40'h00_0000_0001, '1, 1'b0);
        send_region(1'b1, 40'h80_0000_0000, 20'h00001, 1'b0);
        pace_sender();
        send_region(1'b1, 40'h00_0000_8000, 20'h08000, 1'b0);
        send_region(1'b1, 40'h00_0000_0003, 20'h00005, 1'b1);
        send_region(1'b1, 40'hFF_FFFF_8000, 20'h10000, 1'b0);
    endtask

    task automatic test_free_list_chain();
        for (int k = 1; k <= 4; k++)
        begin
            send_region(1'b1, brbs_pkg::PAGE_W'(k * 16), 20'h00010, 1'b0);
            pace_sender();
        end
        send_region(1'b1, 40'h00_0004_0000, 20'h0FFFF, 1'b0);
        send_region(1'b1, 40'h00_0008_0000, 20'h0FFFF, 1'b1);
    endtask

    task automatic test_random_regions();
        logic                         is_free;
        logic [brbs_pkg::PAGE_W-1:0]  first_page;
        logic [brbs_pkg::PAGES_W-1:0] page_count;
        logic                         fin;
        int                           pick;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 3);
            case (pick)
                0: first_page = brbs_pkg::PAGE_W'({$urandom, $urandom});
                1: first_page = brbs_pkg::PAGE_W'($urandom_range(0, 4095));
                2: first_page = '1 - brbs_pkg::PAGE_W'($urandom_range(0, 70000));
                default: first_page = brbs_pkg::PAGE_W'({$urandom, $urandom})
                                      << $urandom_range(0, 39);
            endcase
            pick = $urandom_range(0, 99);
            is_free = (pick >= 8);
            if (pick < 12)
                page_count = (pick < 8) ? brbs_pkg::PAGES_W'($urandom) : '0;
            else if (pick < 70)
                page_count = brbs_pkg::PAGES_W'($urandom_range(1, 200));
            else if (pick < 90)
                page_count = brbs_pkg::PAGES_W'($urandom_range(1, 65535));
            else
                page_count = brbs_pkg::PAGES_W'($urandom);
            fin = ($urandom_range(0, 7) == 0);
            send_region(is_free, first_page, page_count, fin);
            pace_sender();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            got_block = {block_valid, block_order, block_address, bitmap_index,
                         previous_head, last_of_region, end_of_map};
            if (pending_blocks.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected block transfer: valid=%0b order=%0d addr=%h",
                             $realtime, block_valid, block_order, block_address);
            end
            else
            begin
                want_block = pending_blocks.pop_front();
                if (got_block !== want_block)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: block mismatch", $realtime);
                        $display({"  expected valid=%0b order=%0d addr=%h index=%h",
                                  " prev=%h last=%0b end=%0b"},
                                 want_block.valid, want_block.order, want_block.address,
                                 want_block.index, want_block.prev_head, want_block.last,
                                 want_block.eom);
                        $display({"  actual   valid=%0b order=%0d addr=%h index=%h",
                                  " prev=%h last=%0b end=%0b"},
                                 got_block.valid, got_block.order, got_block.address,
                                 got_block.index, got_block.prev_head, got_block.last,
                                 got_block.eom);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_strobe)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < ORDERS; i++)
            list_head[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_skipped_regions();
        test_page_extremes();
        test_free_list_chain();
        test_random_regions();
        start <= 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_blocks.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
